// ===== rtl/core/nearest_greater_or_smaller_index_unit_macros.svh =====
// ----------------------------------------------------------------------------
// nearest_greater_or_smaller_index_unit assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef NEAREST_GREATER_OR_SMALLER_INDEX_UNIT_MACROS_SVH
`define NEAREST_GREATER_OR_SMALLER_INDEX_UNIT_MACROS_SVH

// same-cycle implication
`define NGSI_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NGSI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ngsi_pkg.sv =====
// ----------------------------------------------------------------------------
// ngsi_pkg
// types and fixed field widths shared by the monotonic stack unit
// ----------------------------------------------------------------------------
package ngsi_pkg;

	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_LOAD,
		ST_PUSH
	} ngsi_state_t;

	typedef struct packed {
		logic load_item;
		logic pop;
		logic load_top;
		logic push;
	} ngsi_cmd_t;

	typedef struct packed {
		logic pop_hit;
		logic out_free;
	} ngsi_status_t;

endpackage

// ===== rtl/core/ngsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ngsi_ctrl
// sequencer: accept, compare against stack top, pop and reload, push
// ----------------------------------------------------------------------------
module ngsi_ctrl import ngsi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ngsi_status_t status,
	output ngsi_cmd_t    cmd
);

	ngsi_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = status.pop_hit ? ST_LOAD : ST_PUSH;
			end
			ST_LOAD: begin
				state_d = ST_CMP;
			end
			ST_PUSH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_CMP: begin
				cmd.pop = status.pop_hit;
			end
			ST_LOAD: begin
				cmd.load_top = 1'b1;
			end
			ST_PUSH: begin
				cmd.push = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/ngsi_dp.sv =====
// ----------------------------------------------------------------------------
// ngsi_dp
// stack ring memory, cached top entry, fill and pointers, result register
// ----------------------------------------------------------------------------
`include "nearest_greater_or_smaller_index_unit_macros.svh"

module ngsi_dp import ngsi_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic                cfg_wdata,
	input  logic [SAMPLE_W-1:0] in_value,
	input  logic [POS_W-1:0]    in_pos,
	input  logic                in_first,
	input  ngsi_cmd_t           cmd,
	output ngsi_status_t        status,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [POS_W-1:0]    out_echo_pos,
	output logic                out_found,
	output logic [POS_W-1:0]    out_nbr_pos,
	output logic                out_ovf
);

	localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(STACK_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(STACK_DEPTH);

	logic signed [VALUE_WIDTH-1:0] mem_val [STACK_DEPTH];
	logic        [POS_W-1:0]       mem_pos [STACK_DEPTH];

	logic signed [VALUE_WIDTH-1:0] sample_key;
	logic signed [VALUE_WIDTH-1:0] item_val_q, top_val_q, rd_val_q;
	logic        [POS_W-1:0]       item_pos_q, top_pos_q, rd_pos_q;
	logic                          mode_q;
	logic        [FILL_W-1:0]      fill_q;
	logic        [PTR_W-1:0]       base_q, top_ptr_q;
	logic        [PTR_W-1:0]       ptr_below, ptr_above, base_next, push_slot;
	logic                          full, nonempty, pop_cond;

	logic                          out_valid_q, out_found_q, out_ovf_q;
	logic        [POS_W-1:0]       out_echo_q, out_npos_q;

	// input value as a VALUE_WIDTH two's complement key
	if (VALUE_WIDTH <= SAMPLE_W) begin : g_narrow
		assign sample_key = in_value[VALUE_WIDTH-1:0];
	end else begin : g_wide
		assign sample_key = {{(VALUE_WIDTH - SAMPLE_W){in_value[SAMPLE_W-1]}}, in_value};
	end

	assign full      = (fill_q == FILL_MAX);
	assign nonempty  = (fill_q != '0);
	assign ptr_below = (top_ptr_q == '0) ? PTR_LAST : top_ptr_q - 1'b1;
	assign ptr_above = (top_ptr_q == PTR_LAST) ? '0 : top_ptr_q + 1'b1;
	assign base_next = (base_q == PTR_LAST) ? '0 : base_q + 1'b1;
	assign push_slot = (full || !nonempty) ? base_q : ptr_above;
	assign pop_cond  = mode_q ? (top_val_q >= item_val_q) : (top_val_q <= item_val_q);

	assign status.pop_hit  = nonempty && pop_cond;
	assign status.out_free = !out_valid_q || out_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			fill_q      <= '0;
			base_q      <= '0;
			top_ptr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) mode_q <= cfg_wdata;
			if (cmd.load_item && in_first) begin
				fill_q <= '0;
				base_q <= '0;
			end else if (cmd.pop) begin
				fill_q    <= fill_q - 1'b1;
				top_ptr_q <= ptr_below;
			end else if (cmd.push) begin
				top_ptr_q <= push_slot;
				if (full) begin
					base_q <= base_next;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_val_q <= sample_key;
			item_pos_q <= in_pos;
		end
		if (cmd.load_top) begin
			top_val_q <= rd_val_q;
			top_pos_q <= rd_pos_q;
		end else if (cmd.push) begin
			top_val_q <= item_val_q;
			top_pos_q <= item_pos_q;
		end
		if (cmd.push) begin
			out_echo_q  <= item_pos_q;
			out_found_q <= nonempty;
			out_npos_q  <= nonempty ? top_pos_q : '0;
			out_ovf_q   <= full;
		end
	end

	// stack ring memory
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_val[push_slot] <= item_val_q;
			mem_pos[push_slot] <= item_pos_q;
		end
		if (cmd.pop) begin
			rd_val_q <= mem_val[ptr_below];
			rd_pos_q <= mem_pos[ptr_below];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_echo_pos = out_echo_q;
	assign out_found    = out_found_q;
	assign out_nbr_pos  = out_npos_q;
	assign out_ovf      = out_ovf_q;

	`NGSI_ASSERT_SAME(a_fill_range, clk, arst_n, 1'b1, fill_q <= FILL_MAX, "stack fill beyond depth")
	`NGSI_ASSERT_SAME(a_pop_nonempty, clk, arst_n, cmd.pop, fill_q != '0, "pop on empty stack")
	`NGSI_ASSERT_NEXT(a_push_full_stays, clk, arst_n, cmd.push && full, fill_q == FILL_MAX, "full push changed fill")
	`NGSI_ASSERT_SAME(a_push_out_free, clk, arst_n, cmd.push, !out_valid_q || out_ready, "result overwritten")

endmodule

// ===== rtl/core/nearest_greater_or_smaller_index_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_greater_or_smaller_index_unit
// monotonic stack: nearest earlier strictly greater or smaller element
// ----------------------------------------------------------------------------
// usage:
//   s_* beat: value and position in s_tdata, s_tuser set on the first element
//   of a sequence (empties the stack). m_* beat: one result per input beat.
//   cfg_wen/cfg_wdata write compare_mode (0 greater, 1 smaller) while idle.
// sequence:
//   an item is accepted, compared against the cached top entry, and pushed,
//   which loads the result; each pop in between is one stack memory read plus
//   one reload of the cached top entry, and each entry is popped at most once.
//   a new item is accepted only after the last one has been pushed.
// reset:
//   stack empty, compare_mode 0, no result pending; stack memory contents
//   need no clearing since only entries below the fill are ever read.
// stall:
//   the result register holds while m_tready is low; the next item is still
//   accepted and worked on, and waits before its push until the register frees.
// ----------------------------------------------------------------------------
module nearest_greater_or_smaller_index_unit import ngsi_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // sample_value[31:0], sample_position[41:32], zero pad
	input  logic        s_tuser,  // first_of_sequence
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // echo_position[9:0], neighbor_position[19:10], zero pad
	output logic [1:0]  m_tuser   // neighbor_found[0], stack_overflow[1]
);

	ngsi_cmd_t       cmd;
	ngsi_status_t    status;
	logic [POS_W-1:0] echo_pos, nbr_pos;
	logic            found, ovf;

	ngsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ngsi_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_value     (s_tdata[SAMPLE_W-1:0]),
		.in_pos       (s_tdata[SAMPLE_W+POS_W-1:SAMPLE_W]),
		.in_first     (s_tuser),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_echo_pos (echo_pos),
		.out_found    (found),
		.out_nbr_pos  (nbr_pos),
		.out_ovf      (ovf)
	);

	assign m_tdata = {4'b0000, nbr_pos, echo_pos};
	assign m_tuser = {ovf, found};

endmodule

// ===== verif/tb_nearest_greater_or_smaller_index_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_greater_or_smaller_index_unit
// self-checking bench for the monotonic stack nearest greater/smaller unit
// ----------------------------------------------------------------------------
// a short table of directed beats walks the value extremes, both compare modes,
// equal values, repeated and unordered positions, a mode switch that keeps the
// stack and a clear in the middle of a run. random runs of beats follow, with
// a long receiver hold-off, an overflowing run that wraps the stack, and a
// single beat that pops the whole full stack. every result beat is checked, field by field,
// in order, against an in-bench stack model or, for typed rows, the result in the table.
// ----------------------------------------------------------------------------
module tb_nearest_greater_or_smaller_index_unit import ngsi_pkg::*;;

	localparam int  DEPTH         = 1024;
	localparam int  STALL_LIMIT   = 20000;
	localparam int  HOLD_CYCLES   = 300;
	localparam int  SETTLE_CYCLES = 8;
	localparam logic MODE_GREATER = 1'b0;
	localparam logic MODE_SMALLER = 1'b1;
	localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam int  N_DIRECTED    = 19;

	typedef struct packed {
		logic [POS_W-1:0] echo;
		logic             found;
		logic [POS_W-1:0] npos;
		logic             ovf;
	} result_t;

	typedef struct packed {
		logic                       mode;
		logic signed [SAMPLE_W-1:0] value;
		logic [POS_W-1:0]           pos;
		logic                       first;
		logic                       typed;
		result_t                    res;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // sample_value[31:0], sample_position[41:32], zero pad
	logic        s_tuser;  // first_of_sequence
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // echo_position[9:0], neighbor_position[19:10], zero pad
	logic [1:0]  m_tuser;  // neighbor_found[0], stack_overflow[1]

	logic signed [SAMPLE_W-1:0] stack_vals [DEPTH];
	logic [POS_W-1:0]           stack_poss [DEPTH];
	int                         stack_fill;
	int                         ring_base;
	logic                       find_smaller;

	result_t pending_results [$];
	vector_t directed_rows [N_DIRECTED];
	int      errors;
	int      quiet_cycles;
	int      hold_request;
	bit      idle_en;

	nearest_greater_or_smaller_index_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t nearest_lookup(input logic signed [SAMPLE_W-1:0] v,
			input logic [POS_W-1:0] p, input logic f);
		result_t                    r;
		logic signed [SAMPLE_W-1:0] top;
		bit                         pop;
		int                         s;
		if (f) begin
			stack_fill = 0;
			ring_base  = 0;
		end
		while (stack_fill > 0) begin
			top = stack_vals[(ring_base + stack_fill - 1) % DEPTH];
			pop = find_smaller ? (top >= v) : (top <= v);
			if (!pop)
				break;
			stack_fill--;
		end
		r.echo  = p;
		r.found = (stack_fill > 0);
		r.npos  = (stack_fill > 0) ? stack_poss[(ring_base + stack_fill - 1) % DEPTH] : '0;
		r.ovf   = 1'b0;
		if (stack_fill >= DEPTH) begin
			stack_vals[ring_base] = v;
			stack_poss[ring_base] = p;
			ring_base = (ring_base + 1) % DEPTH;
			r.ovf     = 1'b1;
		end else begin
			s = (ring_base + stack_fill) % DEPTH;
			stack_vals[s] = v;
			stack_poss[s] = p;
			stack_fill++;
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_value(input int style,
			input logic signed [SAMPLE_W-1:0] prev);
		logic signed [SAMPLE_W-1:0] v;
		case (style)
			0: v = int'($urandom_range(0, 16)) - 8;
			1: v = $urandom;
			2: v = prev + int'($urandom_range(0, 10)) - 7;
			default: v = prev + int'($urandom_range(0, 10)) - 3;
		endcase
		if ($urandom_range(0, 19) == 0)
			v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		return v;
	endfunction

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] v, input logic [POS_W-1:0] p,
			input logic f, input logic typed, input result_t typed_res);
		result_t r;
		@(negedge clk);
		while (idle_en && $urandom_range(0, 99) < 30) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {6'b0, p, v};
		s_tuser  = f;
		do
			@(posedge clk);
		while (!s_tready);
		r = nearest_lookup(v, p, f);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain();
		cfg_wen   = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_wen      = 1'b0;
		find_smaller = m;
	endtask

	// runs of beats with increasing or decreasing positions and shaped values
	task automatic run_sequences(input int n_beats);
		int                         sent;
		int                         len;
		int                         style;
		int                         step;
		logic [POS_W-1:0]           pos;
		logic [POS_W-1:0]           p;
		logic signed [SAMPLE_W-1:0] v;
		logic                       f;
		sent = 0;
		v    = '0;
		while (sent < n_beats) begin
			len   = $urandom_range(1, 40);
			style = $urandom_range(0, 3);
			step  = $urandom_range(0, 1) ? 1 : -1;
			pos   = 10'($urandom_range(0, 1023));
			for (int k = 0; k < len; k++) begin
				p = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023)) : pos;
				if (k == 0)
					f = ($urandom_range(0, 9) != 0);
				else
					f = ($urandom_range(0, 49) == 0);
				v = pick_value(style, v);
				push_sample(v, p, f, 1'b0, '0);
				pos  = pos + 10'(step);
				sent++;
			end
		end
	endtask

	// receiver side
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = !(idle_en && $urandom_range(0, 99) < 30);
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: echo_position %0d", m_tdata[9:0]);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[9:0] !== want.echo) begin
					$error("echo_position: expected %0d, actual %0d", want.echo, m_tdata[9:0]);
					errors++;
				end
				if (m_tuser[0] !== want.found) begin
					$error("neighbor_found: expected %0d, actual %0d", want.found, m_tuser[0]);
					errors++;
				end
				if (m_tdata[19:10] !== want.npos) begin
					$error("neighbor_position: expected %0d, actual %0d", want.npos,
						m_tdata[19:10]);
					errors++;
				end
				if (m_tuser[1] !== want.ovf) begin
					$error("stack_overflow: expected %0d, actual %0d", want.ovf, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] v;
		errors       = 0;
		quiet_cycles = 0;
		hold_request = 0;
		idle_en      = 1'b1;
		stack_fill   = 0;
		ring_base    = 0;
		find_smaller = MODE_GREATER;
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_wdata    = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;

		// mode, value, position, first, typed, {echo, found, neighbor, overflow}
		directed_rows = '{
			'{MODE_GREATER, 32'h0000_0000, 10'd0,    1'b1, 1'b1, '{10'd0,    1'b0, 10'd0,    1'b0}},
			'{MODE_GREATER, VAL_MAX,       10'd1023, 1'b0, 1'b1, '{10'd1023, 1'b0, 10'd0,    1'b0}},
			'{MODE_GREATER, VAL_MIN,       10'd1,    1'b0, 1'b1, '{10'd1,    1'b1, 10'd1023, 1'b0}},
			'{MODE_GREATER, VAL_MIN,       10'd2,    1'b0, 1'b1, '{10'd2,    1'b1, 10'd1023, 1'b0}},
			'{MODE_GREATER, 32'h0000_0005, 10'd3,    1'b0, 1'b0, '0},
			'{MODE_GREATER, 32'h0000_0005, 10'd3,    1'b0, 1'b0, '0},
			'{MODE_GREATER, 32'hffff_fffd, 10'd0,    1'b0, 1'b0, '0},
			'{MODE_GREATER, 32'haaaa_aaaa, 10'h2aa,  1'b0, 1'b0, '0},
			'{MODE_GREATER, 32'h5555_5555, 10'h155,  1'b0, 1'b0, '0},
			'{MODE_GREATER, 32'hffff_ffff, 10'd500,  1'b1, 1'b1, '{10'd500,  1'b0, 10'd0,    1'b0}},
			'{MODE_SMALLER, 32'hffff_ffff, 10'd7,    1'b0, 1'b1, '{10'd7,    1'b0, 10'd0,    1'b0}},
			'{MODE_SMALLER, VAL_MAX,       10'd8,    1'b0, 1'b1, '{10'd8,    1'b1, 10'd7,    1'b0}},
			'{MODE_SMALLER, VAL_MIN,       10'd9,    1'b1, 1'b1, '{10'd9,    1'b0, 10'd0,    1'b0}},
			'{MODE_SMALLER, 32'h0000_0000, 10'd10,   1'b0, 1'b0, '0},
			'{MODE_SMALLER, 32'hffff_fffb, 10'd11,   1'b0, 1'b0, '0},
			'{MODE_SMALLER, 32'h0000_0003, 10'd1023, 1'b0, 1'b0, '0},
			'{MODE_SMALLER, 32'h0000_0003, 10'd12,   1'b0, 1'b0, '0},
			'{MODE_GREATER, 32'h0000_0001, 10'd13,   1'b0, 1'b0, '0},
			'{MODE_GREATER, VAL_MAX,       10'd14,   1'b0, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode != find_smaller)
				set_mode(directed_rows[i].mode);
			push_sample(directed_rows[i].value, directed_rows[i].pos, directed_rows[i].first,
				directed_rows[i].typed, directed_rows[i].res);
		end

		run_sequences(200);

		// receiver holds off while beats keep coming
		hold_request = HOLD_CYCLES;
		run_sequences(30);

		set_mode(MODE_SMALLER);
		run_sequences(200);

		// one long falling run overflows and wraps the stack, no idling
		set_mode(MODE_GREATER);
		idle_en = 1'b0;
		v = VAL_MAX;
		push_sample(v, 10'd0, 1'b1, 1'b0, '0);
		for (int i = 1; i < 1040; i++) begin
			v = v - int'($urandom_range(1, 2000000));
			push_sample(v, 10'(i), 1'b0, 1'b0, '0);
		end
		// pops the whole full stack
		push_sample(VAL_MAX, 10'd1023, 1'b0, 1'b0, '0);
		idle_en = 1'b1;

		set_mode(MODE_SMALLER);
		run_sequences(60);
		set_mode(MODE_GREATER);
		run_sequences(60);

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
